>>> sv/tscd_pkg.sv
// Shared types and constants for the Taylor sine/cosine block.
`timescale 1ns / 1ps

package tscd_pkg;

    localparam int FULL_TURN   = 360;
    localparam int PI_NUM      = 314;
    localparam int PI_DEN      = 18000;
    localparam int ANGLE_FRAC  = 28;
    localparam int TERM_FRAC   = 32;

    localparam int DEG_W       = 9;
    localparam int CNT_W       = 6;
    localparam int ANGLE_W     = 31;
    localparam int TERM_W      = 40;
    localparam int SUM_W       = 44;
    localparam int OUT_W       = 32;
    localparam int MOP_W       = 16;
    localparam int PROD_W      = TERM_W + MOP_W;

    localparam int DIV_W       = 48;
    localparam int DIVR_W      = 15;
    localparam int DIV_STEP    = 8;
    localparam int DIV_CYCLES  = DIV_W / DIV_STEP;
    localparam int DIVC_W      = $clog2(DIV_CYCLES);

    localparam logic [TERM_W-1:0] TERM_ONE = TERM_W'(64'd1 << TERM_FRAC);

    typedef struct packed {
        logic [DEG_W-1:0] deg;
        logic [CNT_W-1:0] terms;
    } t_req;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DIVR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

endpackage

>>> sv/tscd_queue.sv
// Two-entry request queue between the front and back ends.
`timescale 1ns / 1ps

module tscd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tscd_pkg::t_req i_req,
    input  logic           i_pop,
    output tscd_pkg::t_req o_req,
    output logic           o_full,
    output logic           o_empty
);
    import tscd_pkg::*;

    t_req       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_req   = r_mem[r_rd_ptr];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

>>> sv/tscd_front.sv
// Front end: accept a request, reduce the angle modulo 360, clamp the term count.
`timescale 1ns / 1ps

module tscd_front #(
    parameter int MAX_TERMS = 16
) (
    input  logic           i_start,
    input  logic           i_full,
    input  logic [15:0]    i_angle_degrees,
    input  logic [4:0]     i_term_count,
    output logic           o_push,
    output tscd_pkg::t_req o_req
);
    import tscd_pkg::*;

    logic [16:0] w_deg;
    logic [16:0] w_step;

    assign o_push = i_start && !i_full;

    always_comb begin
        w_deg = 17'(i_angle_degrees);
        for (int i = 7; i >= 0; i--) begin
            w_step = 17'(FULL_TURN) << i;
            if (w_deg >= w_step) begin
                w_deg = w_deg - w_step;
            end
        end
        o_req.deg = w_deg[DEG_W-1:0];
        if (CNT_W'(i_term_count) > CNT_W'(MAX_TERMS)) begin
            o_req.terms = CNT_W'(MAX_TERMS);
        end else begin
            o_req.terms = CNT_W'(i_term_count);
        end
    end

endmodule

>>> sv/tscd_div.sv
// Shared unsigned divider, eight quotient bits per cycle.
`timescale 1ns / 1ps

module tscd_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tscd_pkg::t_div_req i_req,
    output tscd_pkg::t_div_rsp o_rsp
);
    import tscd_pkg::*;

    logic [DIV_W-1:0]    r_q;
    logic [DIVR_W-1:0]   r_rem;
    logic [DIVR_W-1:0]   r_div;
    logic [DIVC_W-1:0]   r_cnt;
    logic                r_run;
    logic                r_done;

    logic [DIVR_W:0]     w_rem;
    logic [DIV_STEP-1:0] w_qb;

    always_comb begin
        w_rem = {1'b0, r_rem};
        w_qb  = '0;
        for (int i = 0; i < DIV_STEP; i++) begin
            w_rem = {w_rem[DIVR_W-1:0], r_q[DIV_W-1-i]};
            if (w_rem >= {1'b0, r_div}) begin
                w_rem = w_rem - {1'b0, r_div};
                w_qb[DIV_STEP-1-i] = 1'b1;
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_q   <= i_req.dividend;
                r_div <= i_req.divisor;
                r_rem <= '0;
                r_cnt <= '0;
                r_run <= 1'b1;
            end else if (r_run) begin
                r_q   <= {r_q[DIV_W-DIV_STEP-1:0], w_qb};
                r_rem <= w_rem[DIVR_W-1:0];
                r_cnt <= r_cnt + DIVC_W'(1);
                if (r_cnt == DIVC_W'(DIV_CYCLES - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

>>> sv/tscd_back.sv
// Back end: angle to radians, Taylor term recurrence, sums and output rounding.
`timescale 1ns / 1ps

module tscd_back #(
    parameter int RESULT_FRAC_BITS = 22
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_empty,
    input  tscd_pkg::t_req           i_req,
    output logic                     o_pop,
    output tscd_pkg::t_div_req       o_div,
    input  tscd_pkg::t_div_rsp       i_div,
    output logic                     o_valid,
    output logic signed [31:0]       o_sine_value,
    output logic signed [31:0]       o_cosine_value
);
    import tscd_pkg::*;

    localparam int SHIFT = TERM_FRAC - RESULT_FRAC_BITS;
    localparam logic signed [SUM_W:0] HALF    = (SUM_W+1)'(64'sd1 <<< (SHIFT - 1));
    localparam logic signed [SUM_W:0] OUT_MAX = (SUM_W+1)'(64'sd2147483647);
    localparam logic signed [SUM_W:0] OUT_MIN = (SUM_W+1)'(-64'sd2147483648);

    typedef enum logic [2:0] {
        S_IDLE, S_ANG, S_M0, S_M1, S_M2, S_DIV, S_OUT
    } t_state_e;

    t_state_e                r_state;
    logic [CNT_W-1:0]        r_terms;
    logic [CNT_W-1:0]        r_k;
    logic                    r_odd;
    logic [ANGLE_W-1:0]      r_x;
    logic [TERM_W-1:0]       r_t;
    logic [PROD_W-1:0]       r_pp;
    logic [PROD_W-1:0]       r_acc;
    logic signed [SUM_W-1:0] r_sin;
    logic signed [SUM_W-1:0] r_cos;
    logic                    r_valid;
    logic [OUT_W-1:0]        r_sin_out;
    logic [OUT_W-1:0]        r_cos_out;

    logic [MOP_W-1:0]        w_mop;
    logic [PROD_W-1:0]       w_prod;
    logic [PROD_W+15:0]      w_mac;
    logic [6:0]              w_n;
    logic [16:0]             w_deg_pi;
    logic [DIV_W-1:0]        w_ang_num;
    logic signed [SUM_W-1:0] w_t_s;
    logic signed [SUM_W-1:0] w_q_s;
    logic [TERM_W-1:0]       w_q;

    function automatic logic [OUT_W-1:0] round_sat(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W:0] b;
        b = ((SUM_W+1)'(s) + HALF) >>> SHIFT;
        if (b > OUT_MAX) begin
            return OUT_W'(OUT_MAX);
        end else if (b < OUT_MIN) begin
            return OUT_W'(OUT_MIN);
        end
        return OUT_W'(b);
    endfunction

    always_comb begin
        w_mop     = (r_state == S_M0) ? r_x[MOP_W-1:0] : MOP_W'(r_x[ANGLE_W-1:MOP_W]);
        w_prod    = PROD_W'(r_t) * PROD_W'(w_mop);
        w_mac     = (PROD_W+16)'(r_acc) + ((PROD_W+16)'(r_pp) << 16);
        w_n       = 7'({r_k, 1'b0}) + (r_odd ? 7'd1 : 7'd2);
        w_deg_pi  = 17'(i_req.deg) * 17'(PI_NUM);
        w_ang_num = (DIV_W'(w_deg_pi) << ANGLE_FRAC) + DIV_W'(PI_DEN / 2);
        w_t_s     = $signed(SUM_W'(r_t));
        w_q       = i_div.quotient[TERM_W-1:0];
        w_q_s     = $signed(SUM_W'(w_q));

        o_pop          = (r_state == S_IDLE) && !i_empty;
        o_div.start    = o_pop || (r_state == S_M2);
        o_div.dividend = (r_state == S_IDLE) ? w_ang_num : DIV_W'(w_mac >> ANGLE_FRAC);
        o_div.divisor  = (r_state == S_IDLE) ? DIVR_W'(PI_DEN) : DIVR_W'(w_n);
    end

    assign o_valid        = r_valid;
    assign o_sine_value   = $signed(r_sin_out);
    assign o_cosine_value = $signed(r_cos_out);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_terms <= i_req.terms;
                        r_state <= S_ANG;
                    end
                end
                S_ANG: begin
                    if (i_div.done) begin
                        r_x   <= i_div.quotient[ANGLE_W-1:0];
                        r_t   <= TERM_ONE;
                        r_k   <= '0;
                        r_odd <= 1'b1;
                        r_sin <= '0;
                        r_cos <= '0;
                        r_state <= (r_terms == '0) ? S_OUT : S_M0;
                    end
                end
                S_M0: begin
                    r_pp <= w_prod;
                    if (r_odd) begin
                        r_cos <= r_k[0] ? r_cos - w_t_s : r_cos + w_t_s;
                    end
                    r_state <= S_M1;
                end
                S_M1: begin
                    r_acc   <= r_pp;
                    r_pp    <= w_prod;
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (i_div.done) begin
                        r_t <= w_q;
                        if (r_odd) begin
                            r_sin <= r_k[0] ? r_sin - w_q_s : r_sin + w_q_s;
                            if (r_k + CNT_W'(1) == r_terms) begin
                                r_state <= S_OUT;
                            end else begin
                                r_odd   <= 1'b0;
                                r_state <= S_M0;
                            end
                        end else begin
                            r_k     <= r_k + CNT_W'(1);
                            r_odd   <= 1'b1;
                            r_state <= S_M0;
                        end
                    end
                end
                S_OUT: begin
                    r_sin_out <= round_sat(r_sin);
                    r_cos_out <= round_sat(r_cos);
                    r_valid   <= 1'b1;
                    r_state   <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

>>> sv/taylor_sine_cosine_degrees.sv
// Top level of the Taylor-series sine/cosine of an angle in whole degrees.
//
// Channel   Direction  Handshake                Payload
// request   in         start, busy              i_angle_degrees, i_term_count
// result    out        o_valid (one-cycle)      o_sine_value, o_cosine_value
//
// With n terms after clamping, a request holds the back end while it pops, runs the
// degree-to-radian division, runs 2*n - 1 term steps (none when n is zero; each uses the
// shared 40x16 multiplier in S_M0 and S_M1, then waits in S_DIV on the shared divider,
// which retires eight quotient bits a cycle) and rounds.
// Up to two requests wait in the queue; busy is high while it is full.
// Reset is synchronous, active low, and clears the queue and both sequencers.
// Results cannot be stalled: each is shown for one cycle with o_valid high.
`timescale 1ns / 1ps

module taylor_sine_cosine_degrees #(
    parameter int MAX_TERMS        = 16,
    parameter int RESULT_FRAC_BITS = 22
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [15:0]        i_angle_degrees,
    input  logic [4:0]         i_term_count,
    output logic               o_valid,
    output logic signed [31:0] o_sine_value,
    output logic signed [31:0] o_cosine_value
);
    import tscd_pkg::*;

    logic     w_push;
    logic     w_pop;
    logic     w_full;
    logic     w_empty;
    t_req     w_in_req;
    t_req     w_head;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;

    assign busy = w_full;

    tscd_front #(
        .MAX_TERMS(MAX_TERMS)
    ) u_front (
        .i_start        (start),
        .i_full         (w_full),
        .i_angle_degrees(i_angle_degrees),
        .i_term_count   (i_term_count),
        .o_push         (w_push),
        .o_req          (w_in_req)
    );

    tscd_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_req  (w_in_req),
        .i_pop  (w_pop),
        .o_req  (w_head),
        .o_full (w_full),
        .o_empty(w_empty)
    );

    tscd_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_div_req),
        .o_rsp  (w_div_rsp)
    );

    tscd_back #(
        .RESULT_FRAC_BITS(RESULT_FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_req         (w_head),
        .o_pop         (w_pop),
        .o_div         (w_div_req),
        .i_div         (w_div_rsp),
        .o_valid       (o_valid),
        .o_sine_value  (o_sine_value),
        .o_cosine_value(o_cosine_value)
    );

endmodule
